### hdl/bums_pkg.sv
// Shared constants and types of the bottom-up merge sorter.
`default_nettype none

package bums_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic we_a;
    logic we_b;
    logic src_sel;
  } bums_memctl_t;

endpackage

`default_nettype wire

### hdl/bums_ram.sv
// Synchronous memory with one write port and two registered read ports.
`default_nettype none

module bums_ram
  import bums_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [DATA_W-1:0]          wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr0,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr1,
  output logic      [DATA_W-1:0]          rd_data0,
  output logic      [DATA_W-1:0]          rd_data1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

`default_nettype wire

### hdl/bums_seq.sv
// Sequencer of the sorter: load, merge passes, drain and the output register.
`default_nettype none

module bums_seq
  import bums_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [DATA_W-1:0]   value,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DATA_W-1:0]        sorted_value,
  output logic                            last_out,
  output logic                            overflowed,
  output bums_memctl_t                    memctl,
  output logic [$clog2(DEPTH)-1:0]        wr_addr,
  output logic [DATA_W-1:0]               wr_data,
  output logic [$clog2(DEPTH)-1:0]        rd_addr0,
  output logic [$clog2(DEPTH)-1:0]        rd_addr1,
  input  wire logic [DATA_W-1:0]          rd_data0,
  input  wire logic [DATA_W-1:0]          rd_data1
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH) + 2;
  localparam logic [SW-1:0] DEPTH_C = SW'(DEPTH);
  localparam logic [SW-1:0] ONE_C = SW'(1);

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_BLOCK  = 7'b0000100,
    S_MREAD  = 7'b0001000,
    S_MWRITE = 7'b0010000,
    S_DREAD  = 7'b0100000,
    S_DOUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [SW-1:0] cnt;
  logic ovf;
  logic [SW-1:0] w;
  logic src_sel;
  logic [SW-1:0] lo;
  logic [SW-1:0] mid;
  logic [SW-1:0] hi;
  logic [SW-1:0] i;
  logic [SW-1:0] j;
  logic [SW-1:0] k;
  logic out_valid_r;
  logic signed [DATA_W-1:0] sorted_r;
  logic last_r;
  logic ovf_r;

  logic [SW-1:0] lo_w;
  logic [SW-1:0] lo_2w;
  logic [SW-1:0] mid_calc;
  logic [SW-1:0] hi_calc;
  logic [SW-1:0] k_inc;
  logic [SW-1:0] w_dbl;
  logic take_left;
  logic out_load;
  logic room;

  assign lo_w = lo + w;
  assign w_dbl = w << 1;
  assign lo_2w = lo + w_dbl;
  assign mid_calc = (lo_w < cnt) ? lo_w : cnt;
  assign hi_calc = (lo_2w < cnt) ? lo_2w : cnt;
  assign k_inc = k + ONE_C;
  assign take_left = (i < mid) &&
                     ((j >= hi) || ($signed(rd_data0) <= $signed(rd_data1)));
  assign out_load = (state == S_DOUT) && (!out_valid_r || !out_stall);
  assign room = cnt < DEPTH_C;

  assign in_stall = (state != S_LOAD);
  assign out_valid = out_valid_r;
  assign sorted_value = sorted_r;
  assign last_out = last_r;
  assign overflowed = ovf_r;

  always_comb begin
    memctl.src_sel = src_sel;
    memctl.we_a = ((state == S_LOAD) && in_valid && room) ||
                  ((state == S_MWRITE) && src_sel);
    memctl.we_b = (state == S_MWRITE) && !src_sel;
    wr_addr = (state == S_LOAD) ? cnt[AW-1:0] : k[AW-1:0];
    wr_data = (state == S_LOAD) ? value : (take_left ? rd_data0 : rd_data1);
    rd_addr0 = (state == S_MREAD) ? i[AW-1:0] : k[AW-1:0];
    rd_addr1 = j[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0;
      ovf <= 1'b0;
      w <= ONE_C;
      src_sel <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              cnt <= cnt + ONE_C;
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          src_sel <= 1'b0;
          w <= ONE_C;
          state <= (cnt <= ONE_C) ? S_DREAD : S_BLOCK;
        end
        S_BLOCK: begin
          state <= S_MREAD;
        end
        S_MREAD: begin
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          if (k_inc == hi) begin
            if (hi == cnt) begin
              src_sel <= !src_sel;
              w <= w_dbl;
              state <= (w_dbl >= cnt) ? S_DREAD : S_BLOCK;
            end else begin
              state <= S_BLOCK;
            end
          end else begin
            state <= S_MREAD;
          end
        end
        S_DREAD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (k_inc == cnt) begin
              cnt <= '0;
              ovf <= 1'b0;
              w <= ONE_C;
              state <= S_LOAD;
            end else begin
              state <= S_DREAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_PREP: begin
        lo <= '0;
        k <= '0;
      end
      S_BLOCK: begin
        i <= lo;
        mid <= mid_calc;
        j <= mid_calc;
        hi <= hi_calc;
      end
      S_MWRITE: begin
        if (take_left) begin
          i <= i + ONE_C;
        end else begin
          j <= j + ONE_C;
        end
        if ((k_inc == hi) && (hi == cnt)) begin
          lo <= '0;
          k <= '0;
        end else begin
          k <= k_inc;
          if (k_inc == hi) begin
            lo <= hi;
          end
        end
      end
      S_DOUT: begin
        if (out_load) begin
          sorted_r <= $signed(rd_data0);
          last_r <= (k_inc == cnt);
          ovf_r <= ovf;
          k <= k_inc;
        end
      end
      default: begin
      end
    endcase
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(memctl.we_a && memctl.we_b))
    else $error("Both stores written in the same cycle.");

  a_merge_has_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWRITE) |-> ((i < mid) || (j < hi)))
    else $error("Merge step with both runs exhausted.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("Element count beyond capacity.");

  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    (out_load && (k_inc == cnt)) |=> ((state == S_LOAD) && (cnt == '0) && !ovf))
    else $error("Set state not cleared after the final value.");

endmodule

`default_nettype wire

### hdl/bottom_up_merge_sorter_unit.sv
// Top level of the bottom-up merge sorter: two stores and the sequencer.
`default_nettype none

// The block takes one value per cycle while it loads a set, keeping up to
// DEPTH values and dropping the rest with the overflow mark. The item marked
// last starts ceil(log2(n)) merge passes between two stores. Each pass sets
// up every pair of runs in one step and then, for each element, reads both
// run heads from the source store and compares them and writes one into
// the other store. The sorted values then leave from the final store, each
// read and then loaded into the output register, which waits while a held
// value is stalled. No input is taken from the marked last item until the
// final value has entered the output register.
module bottom_up_merge_sorter_unit
  import bums_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [DATA_W-1:0]   value,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DATA_W-1:0]        sorted_value,
  output logic                            last_out,
  output logic                            overflowed
);

  localparam int AW = $clog2(DEPTH);

  bums_memctl_t memctl;
  logic [AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  logic [DATA_W-1:0] a_rd0;
  logic [DATA_W-1:0] a_rd1;
  logic [DATA_W-1:0] b_rd0;
  logic [DATA_W-1:0] b_rd1;
  logic [DATA_W-1:0] rd_data0;
  logic [DATA_W-1:0] rd_data1;

  assign rd_data0 = memctl.src_sel ? b_rd0 : a_rd0;
  assign rd_data1 = memctl.src_sel ? b_rd1 : a_rd1;

  bums_ram #(.DEPTH(DEPTH)) u_store_a (
    .clk      (clk),
    .we       (memctl.we_a),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (a_rd0),
    .rd_data1 (a_rd1)
  );

  bums_ram #(.DEPTH(DEPTH)) u_store_b (
    .clk      (clk),
    .we       (memctl.we_b),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (b_rd0),
    .rd_data1 (b_rd1)
  );

  bums_seq #(.DEPTH(DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflowed   (overflowed),
    .memctl       (memctl),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr0     (rd_addr0),
    .rd_addr1     (rd_addr1),
    .rd_data0     (rd_data0),
    .rd_data1     (rd_data1)
  );

endmodule

`default_nettype wire
